// ===== rtl/core/etl_pkg.sv =====
// shared types, constants and character codes of the expression token lexer
package etl_pkg;

  localparam int unsigned MaxLenDefault = 4096;
  localparam int unsigned TokStartW     = 12;
  localparam int unsigned TokLenW       = 13;
  localparam int unsigned FifoDepth     = 4;

  localparam logic [7:0] CharPlus       = 8'h2B;
  localparam logic [7:0] CharMinus      = 8'h2D;
  localparam logic [7:0] CharStar       = 8'h2A;
  localparam logic [7:0] CharSlash      = 8'h2F;
  localparam logic [7:0] CharPercent    = 8'h25;
  localparam logic [7:0] CharLParen     = 8'h28;
  localparam logic [7:0] CharRParen     = 8'h29;
  localparam logic [7:0] CharNul        = 8'h00;
  localparam logic [7:0] CharUnderscore = 8'h5F;
  localparam logic [7:0] CharSpace      = 8'h20;
  localparam logic [7:0] CharTab        = 8'h09;
  localparam logic [7:0] CharCr         = 8'h0D;
  localparam logic [7:0] Char0          = 8'h30;
  localparam logic [7:0] Char9          = 8'h39;
  localparam logic [7:0] CharLowA       = 8'h61;
  localparam logic [7:0] CharLowZ       = 8'h7A;
  localparam logic [7:0] CharUpA        = 8'h41;
  localparam logic [7:0] CharUpZ        = 8'h5A;

  typedef enum logic [3:0] {
    TOK_VAR   = 4'd0,
    TOK_LIT   = 4'd1,
    TOK_ADD   = 4'd2,
    TOK_SUB   = 4'd3,
    TOK_MUL   = 4'd4,
    TOK_DIV   = 4'd5,
    TOK_MOD   = 4'd6,
    TOK_INC   = 4'd7,
    TOK_DEC   = 4'd8,
    TOK_OPEN  = 4'd9,
    TOK_CLOSE = 4'd10,
    TOK_BAD   = 4'd11,
    TOK_EOF   = 4'd12
  } tok_type_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0]           token_type;
    logic [TokStartW-1:0] token_start;
    logic [TokLenW-1:0]   token_length;
    logic                 token_last;
  } token_t;

  typedef struct packed {
    logic   a_valid;
    token_t a;
    logic   b_valid;
    token_t b;
  } lex_out_t;

endpackage

// ===== rtl/core/etl_lexer.sv =====
// character classing, token grouping state and token build of the lexer
module etl_lexer import etl_pkg::*; #(
  parameter int unsigned MaxLen = MaxLenDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_item_t item_i,
  output lex_out_t tokens_o
);

  localparam int unsigned PosW = $clog2(MaxLen);
  localparam int unsigned LenW = $clog2(MaxLen + 1);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_LIT,
    MODE_ILLEGAL,
    MODE_OP,
    MODE_NUL
  } mode_e;

  mode_e            mode_q, mode_d, mode_open;
  tok_type_e        type_q, type_d;
  logic [PosW-1:0]  start_q, start_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [PosW-1:0]  pos_q, pos_d;

  tok_type_e cls;
  logic      spc, paren, grows, ext, open_new, b_paren, b_flush;
  lex_out_t  tok;

  function automatic tok_type_e classify(input logic [7:0] ch);
    tok_type_e res;
    if (ch >= Char0 && ch <= Char9) begin
      res = TOK_LIT;
    end else if ((ch >= CharLowA && ch <= CharLowZ) || (ch >= CharUpA && ch <= CharUpZ) ||
                 ch == CharUnderscore) begin
      res = TOK_VAR;
    end else begin
      case (ch)
        CharPlus:    res = TOK_ADD;
        CharMinus:   res = TOK_SUB;
        CharStar:    res = TOK_MUL;
        CharSlash:   res = TOK_DIV;
        CharPercent: res = TOK_MOD;
        CharLParen:  res = TOK_OPEN;
        CharRParen:  res = TOK_CLOSE;
        CharNul:     res = TOK_EOF;
        default:     res = TOK_BAD;
      endcase
    end
    return res;
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return ch == CharSpace || (ch >= CharTab && ch <= CharCr);
  endfunction

  function automatic mode_e mode_for(input tok_type_e c);
    mode_e m;
    case (c)
      TOK_VAR: m = MODE_IDENT;
      TOK_LIT: m = MODE_LIT;
      TOK_BAD: m = MODE_ILLEGAL;
      TOK_EOF: m = MODE_NUL;
      default: m = MODE_OP;
    endcase
    return m;
  endfunction

  function automatic tok_type_e final_type(input mode_e m, input tok_type_e t,
                                           input logic [LenW-1:0] len);
    tok_type_e res;
    res = t;
    if (m == MODE_OP) begin
      if (t == TOK_ADD || t == TOK_SUB) begin
        if (len == LenW'(1)) begin
          res = t;
        end else if (len == LenW'(2)) begin
          res = (t == TOK_ADD) ? TOK_INC : TOK_DEC;
        end else begin
          res = TOK_BAD;
        end
      end else begin
        res = (len == LenW'(1)) ? t : TOK_BAD;
      end
    end
    return res;
  endfunction

  function automatic logic [TokStartW-1:0] to_start(input logic [PosW-1:0] p);
    return TokStartW'(32'(p));
  endfunction

  function automatic logic [TokLenW-1:0] to_len(input logic [LenW-1:0] l);
    return TokLenW'(32'(l));
  endfunction

  always_comb begin
    cls   = classify(item_i.char_byte);
    spc   = is_space(item_i.char_byte);
    paren = (cls == TOK_OPEN) || (cls == TOK_CLOSE);

    case (mode_q)
      MODE_IDENT:   grows = !spc && (cls == TOK_VAR || cls == TOK_LIT);
      MODE_LIT:     grows = !spc && (cls == TOK_LIT);
      MODE_ILLEGAL: grows = !spc;
      MODE_OP:      grows = !spc && (cls == type_q);
      MODE_NUL:     grows = !spc && (cls == TOK_EOF);
      default:      grows = 1'b0;
    endcase
    ext = (mode_q != MODE_IDLE) && grows;

    tok = '0;
    tok.a_valid            = (mode_q != MODE_IDLE) && !ext;
    tok.a.token_type       = final_type(mode_q, type_q, len_q);
    tok.a.token_start      = to_start(start_q);
    tok.a.token_length     = to_len(len_q);

    mode_open = tok.a_valid ? MODE_IDLE : mode_q;
    type_d    = type_q;
    start_d   = start_q;
    len_d     = len_q;
    open_new  = !ext && !spc && !paren;
    b_paren   = !ext && !spc && paren;

    if (ext) begin
      if (len_q < LenW'(MaxLen)) begin
        len_d = len_q + LenW'(1);
      end
    end else if (open_new) begin
      mode_open = mode_for(cls);
      type_d    = cls;
      start_d   = pos_q;
      len_d     = LenW'(1);
    end

    // final character flushes whatever is still open
    b_flush = item_i.end_of_input && (mode_open != MODE_IDLE);
    mode_d  = item_i.end_of_input ? MODE_IDLE : mode_open;

    tok.b_valid = b_paren || b_flush;
    if (b_paren) begin
      tok.b.token_type   = cls;
      tok.b.token_start  = to_start(pos_q);
      tok.b.token_length = TokLenW'(1);
    end else begin
      tok.b.token_type   = final_type(mode_open, type_d, len_d);
      tok.b.token_start  = to_start(start_d);
      tok.b.token_length = to_len(len_d);
    end

    if (item_i.end_of_input) begin
      if (tok.b_valid) begin
        tok.b.token_last = 1'b1;
      end else begin
        tok.a.token_last = tok.a_valid;
      end
    end

    if (item_i.end_of_input) begin
      pos_d = '0;
    end else if (pos_q < PosW'(MaxLen - 1)) begin
      pos_d = pos_q + PosW'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  assign tokens_o = tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      type_q  <= TOK_VAR;
      start_q <= '0;
      len_q   <= '0;
      pos_q   <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      type_q  <= type_d;
      start_q <= start_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
    end
  end

endmodule

// ===== rtl/core/etl_token_fifo.sv =====
// token queue taking up to two tokens per cycle and giving one per cycle while the reader is ready
module etl_token_fifo import etl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lex_out_t tokens_i,
  output logic     space2_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output token_t   out_data_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  token_t          mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_b;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push_a, push_b, pop;

  assign push_a      = push_i && tokens_i.a_valid;
  assign push_b      = push_i && tokens_i.b_valid;
  assign pop         = out_valid_o && out_ready_i;
  assign wr_b        = wr_q + PtrW'(push_a);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  assign space2_o    = cnt_q <= CntW'(FifoDepth - 2);

  always_comb begin
    wr_d  = wr_q + PtrW'(push_a) + PtrW'(push_b);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(push_a) + CntW'(push_b) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FifoDepth; i++) begin
      if (push_a && wr_q == PtrW'(i)) begin
        mem_q[i] <= tokens_i.a;
      end else if (push_b && wr_b == PtrW'(i)) begin
        mem_q[i] <= tokens_i.b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/expression_token_lexer_top.sv =====
// Expression token lexer: one character item per cycle enters an input register, is classed and
// grouped in a single pass, and the 0, 1 or 2 tokens it closes go into a four-entry token queue
// that hands out one token item per cycle while the output is ready. An item is taken every
// cycle while the queue holds two entries or fewer, so the input rate is one character per
// cycle and the token rate is set by the output port at one token per cycle. The character that
// closes a token waits in the input register while the queue holds more than two entries.
// Positions saturate at MAX_LEN-1 and lengths at MAX_LEN.
module expression_token_lexer_top import etl_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output token_t   out_data_o
);

  logic     in_valid_q, in_valid_d;
  in_item_t in_q;
  logic     space2, advance, accept;
  lex_out_t tokens;

  assign advance    = in_valid_q && space2;
  assign in_ready_o = !in_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  etl_lexer #(
    .MaxLen(MAX_LEN)
  ) u_lexer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (in_q),
    .tokens_o(tokens)
  );

  etl_token_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (advance),
    .tokens_i   (tokens),
    .space2_o   (space2),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== rtl/core/etl_checker.sv =====
// port-level checks on the expression token lexer and their binding to the top level
module etl_checker import etl_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input token_t   out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("token item changed while stalled");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.token_length != '0)
    else $error("token with zero length");

  a_single_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.token_type == TOK_OPEN || out_data_i.token_type == TOK_CLOSE ||
                    out_data_i.token_type == TOK_ADD || out_data_i.token_type == TOK_SUB ||
                    out_data_i.token_type == TOK_MUL || out_data_i.token_type == TOK_DIV ||
                    out_data_i.token_type == TOK_MOD)
    |-> out_data_i.token_length == TokLenW'(1))
    else $error("single-character token with wrong length");

  a_double_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.token_type == TOK_INC || out_data_i.token_type == TOK_DEC)
    |-> out_data_i.token_length == TokLenW'(2))
    else $error("increment or decrement token with wrong length");

endmodule

bind expression_token_lexer_top etl_checker u_etl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_i (out_data_o)
);
